@@ src/tmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// tmhq_pkg - shared definitions for the triangle max-height query core
// Field layout of the input transfer, output height width and divider status.
// ----------------------------------------------------------------------------
package tmhq_pkg;

    // result height is always emitted at this width
    localparam int HEIGHT_W   = 16;
    // coordinate fields carried in s_tdata
    localparam int NUM_FIELDS = 11;

    // field slots in s_tdata, lowest first
    localparam int F_QX = 0;
    localparam int F_QY = 1;
    localparam int F_AX = 2;
    localparam int F_AY = 3;
    localparam int F_AZ = 4;
    localparam int F_BX = 5;
    localparam int F_BY = 6;
    localparam int F_BZ = 7;
    localparam int F_CX = 8;
    localparam int F_CY = 9;
    localparam int F_CZ = 10;

    // status returned by the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ src/tmhq_mul.sv @@
// ----------------------------------------------------------------------------
// tmhq_mul - shared signed multiplier
// One registered signed multiply per cycle, reused by every step of the sequencer.
// ----------------------------------------------------------------------------
module tmhq_mul #(
    parameter int MUL_W = 19
) (
    input  logic                      aclk,
    input  logic signed [MUL_W-1:0]   op_a,
    input  logic signed [MUL_W-1:0]   op_b,
    output logic signed [2*MUL_W-1:0] prod
);

    logic signed [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

@@ src/tmhq_div.sv @@
// ----------------------------------------------------------------------------
// tmhq_div - serial restoring divider
// Unsigned magnitude divide, one quotient bit per cycle. The caller guarantees
// the quotient fits in CB bits, so only the low CB dividend bits are iterated.
// ----------------------------------------------------------------------------
module tmhq_div #(
    parameter int CB    = 16,
    parameter int NUM_W = 54,
    parameter int DEN_W = 34
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [NUM_W-1:0]        dividend,
    input  logic [DEN_W-1:0]        divisor,
    output logic [CB-1:0]           quotient,
    output tmhq_pkg::div_stat_t     stat
);
    import tmhq_pkg::*;

    localparam int R_W   = DEN_W + 1;
    localparam int CNT_W = $clog2(CB + 1);

    logic [R_W-1:0]   rem_reg;
    logic [CB-1:0]    quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [R_W-1:0]   trial;
    logic             ge;

    assign trial = {rem_reg[R_W-2:0], quo_reg[CB-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(CB);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // high part of the dividend is already below the divisor
            rem_reg <= dividend[CB +: R_W];
            quo_reg <= dividend[CB-1:0];
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[CB-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_fall_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> done_reg)
        else $error("divider went idle without done");

endmodule

@@ src/triangle_max_height_query_core.sv @@
// ----------------------------------------------------------------------------
// triangle_max_height_query_core - max terrain height over triangles at a point
// Point-in-triangle test with barycentric height interpolation, running max.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one triangle per transfer together with the query point;
//   s_tlast marks the final triangle of a query. After the final triangle one
//   result transfer leaves on m_*: m_tuser = found, m_tdata = height (0 when
//   nothing was hit). Other triangles produce no output transfer.
//   Each triangle runs 14 products plus an accumulate drain step on the shared
//   multiplier, then a decision step, a divider run for a hit, and a finish
//   step, all after the accept. s_tready is high only while the block is idle.
//   Reset clears the running maximum, the found flag and the output register.
//   The result sits in an output register; if it has not been taken when the
//   next query finishes, the block waits in its finish step until m_tready.
// ----------------------------------------------------------------------------
module triangle_max_height_query_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // s_tdata, low to high: query_x, query_y, vertex_a_x, vertex_a_y, vertex_a_z,
    // vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z
    input  logic [((11*COORD_BITS+7)/8)*8-1:0]            s_tdata,
    input  logic                                         s_tlast,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // m_tdata: height
    output logic [tmhq_pkg::HEIGHT_W-1:0]                m_tdata,
    // m_tuser: found
    output logic                                         m_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready
);
    import tmhq_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int DIFF_W = CB + 1;
    localparam int MUL_W  = CB + 3;
    localparam int PROD_W = 2 * MUL_W;
    localparam int W_W    = 2 * CB + 2;
    localparam int K      = CB + 2;
    localparam int NUM_W  = 3 * CB + 6;
    localparam int TD_W   = ((11 * COORD_BITS + 7) / 8) * 8;

    // multiplier steps
    localparam logic [3:0] S_AREA_P = 4'd0;
    localparam logic [3:0] S_AREA_Q = 4'd1;
    localparam logic [3:0] S_WA_P   = 4'd2;
    localparam logic [3:0] S_WA_Q   = 4'd3;
    localparam logic [3:0] S_WB_P   = 4'd4;
    localparam logic [3:0] S_WB_Q   = 4'd5;
    localparam logic [3:0] S_WC_P   = 4'd6;
    localparam logic [3:0] S_WC_Q   = 4'd7;
    localparam logic [3:0] S_ZA_LO  = 4'd8;
    localparam logic [3:0] S_ZA_HI  = 4'd9;
    localparam logic [3:0] S_ZB_LO  = 4'd10;
    localparam logic [3:0] S_ZB_HI  = 4'd11;
    localparam logic [3:0] S_ZC_LO  = 4'd12;
    localparam logic [3:0] S_ZC_HI  = 4'd13;
    localparam logic [3:0] S_DRAIN  = 4'd14;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DECIDE,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [3:0]             step_reg;
    logic [3:0]             acc_step_reg;
    logic                   acc_en_reg;
    logic [TD_W-1:0]        in_reg;
    logic                   last_reg;
    logic signed [W_W-1:0]  area_reg;
    logic signed [W_W-1:0]  wa_reg;
    logic signed [W_W-1:0]  wb_reg;
    logic signed [W_W-1:0]  wc_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic                   neg_reg;
    logic signed [CB-1:0]   best_height_reg;
    logic                   any_hit_reg;
    logic                   m_tvalid_reg;
    logic                   m_tuser_reg;
    logic [HEIGHT_W-1:0]    m_tdata_reg;

    logic signed [CB-1:0]   px, py, ax, ay, az, bx, by, bz, cx, cy, cz;
    logic signed [MUL_W-1:0] op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    logic                   hit;
    logic                   div_start;
    logic [NUM_W-1:0]       num_mag;
    logic [W_W-1:0]         area_mag;
    logic [CB-1:0]          quotient;
    div_stat_t              div_stat;
    logic signed [CB-1:0]   h_val;

    assign px = $signed(in_reg[F_QX*CB +: CB]);
    assign py = $signed(in_reg[F_QY*CB +: CB]);
    assign ax = $signed(in_reg[F_AX*CB +: CB]);
    assign ay = $signed(in_reg[F_AY*CB +: CB]);
    assign az = $signed(in_reg[F_AZ*CB +: CB]);
    assign bx = $signed(in_reg[F_BX*CB +: CB]);
    assign by = $signed(in_reg[F_BY*CB +: CB]);
    assign bz = $signed(in_reg[F_BZ*CB +: CB]);
    assign cx = $signed(in_reg[F_CX*CB +: CB]);
    assign cy = $signed(in_reg[F_CY*CB +: CB]);
    assign cz = $signed(in_reg[F_CZ*CB +: CB]);

    function automatic logic signed [MUL_W-1:0] diff_op(
        input logic signed [CB-1:0] a,
        input logic signed [CB-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return MUL_W'(d);
    endfunction

    // weight split: unsigned low K bits and signed high part
    function automatic logic signed [MUL_W-1:0] w_lo(input logic signed [W_W-1:0] w);
        return $signed({1'b0, w[K-1:0]});
    endfunction

    function automatic logic signed [MUL_W-1:0] w_hi(input logic signed [W_W-1:0] w);
        return MUL_W'($signed(w[W_W-1:K]));
    endfunction

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (step_reg)
            S_AREA_P: begin op_a = diff_op(bx, ax); op_b = diff_op(cy, ay); end
            S_AREA_Q: begin op_a = diff_op(by, ay); op_b = diff_op(cx, ax); end
            S_WA_P:   begin op_a = diff_op(bx, px); op_b = diff_op(cy, py); end
            S_WA_Q:   begin op_a = diff_op(by, py); op_b = diff_op(cx, px); end
            S_WB_P:   begin op_a = diff_op(cx, px); op_b = diff_op(ay, py); end
            S_WB_Q:   begin op_a = diff_op(cy, py); op_b = diff_op(ax, px); end
            S_WC_P:   begin op_a = diff_op(ax, px); op_b = diff_op(by, py); end
            S_WC_Q:   begin op_a = diff_op(ay, py); op_b = diff_op(bx, px); end
            S_ZA_LO:  begin op_a = MUL_W'(az); op_b = w_lo(wa_reg); end
            S_ZA_HI:  begin op_a = MUL_W'(az); op_b = w_hi(wa_reg); end
            S_ZB_LO:  begin op_a = MUL_W'(bz); op_b = w_lo(wb_reg); end
            S_ZB_HI:  begin op_a = MUL_W'(bz); op_b = w_hi(wb_reg); end
            S_ZC_LO:  begin op_a = MUL_W'(cz); op_b = w_lo(wc_reg); end
            S_ZC_HI:  begin op_a = MUL_W'(cz); op_b = w_hi(wc_reg); end
            default:  begin op_a = '0; op_b = '0; end
        endcase
    end

    tmhq_mul #(
        .MUL_W (MUL_W)
    ) u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // containment: zero cross counts as inside, zero area never hits
    always_comb begin
        if (area_reg == '0) begin
            hit = 1'b0;
        end else if (area_reg[W_W-1]) begin
            hit = (wa_reg[W_W-1] || wa_reg == '0) && (wb_reg[W_W-1] || wb_reg == '0) &&
                  (wc_reg[W_W-1] || wc_reg == '0);
        end else begin
            hit = !wa_reg[W_W-1] && !wb_reg[W_W-1] && !wc_reg[W_W-1];
        end
    end

    assign num_mag   = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign area_mag  = area_reg[W_W-1] ? W_W'(-area_reg) : W_W'(area_reg);
    assign div_start = (state_reg == ST_DECIDE) && hit;

    tmhq_div #(
        .CB    (CB),
        .NUM_W (NUM_W),
        .DEN_W (W_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  (area_mag),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign h_val = neg_reg ? -$signed(quotient) : $signed(quotient);

    // product accumulation, driven by registered copies of the multiplier step and enable
    always_ff @(posedge aclk) begin
        if (acc_en_reg) begin
            unique case (acc_step_reg)
                S_AREA_P: area_reg <= W_W'(prod);
                S_AREA_Q: area_reg <= area_reg - W_W'(prod);
                S_WA_P:   wa_reg   <= W_W'(prod);
                S_WA_Q:   wa_reg   <= wa_reg - W_W'(prod);
                S_WB_P:   wb_reg   <= W_W'(prod);
                S_WB_Q:   wb_reg   <= wb_reg - W_W'(prod);
                S_WC_P:   wc_reg   <= W_W'(prod);
                S_WC_Q:   wc_reg   <= wc_reg - W_W'(prod);
                S_ZA_LO:  num_reg  <= NUM_W'(prod);
                S_ZA_HI:  num_reg  <= num_reg + (NUM_W'(prod) <<< K);
                S_ZB_LO:  num_reg  <= num_reg + NUM_W'(prod);
                S_ZB_HI:  num_reg  <= num_reg + (NUM_W'(prod) <<< K);
                S_ZC_LO:  num_reg  <= num_reg + NUM_W'(prod);
                S_ZC_HI:  num_reg  <= num_reg + (NUM_W'(prod) <<< K);
                default:  num_reg  <= num_reg;
            endcase
        end
        if (s_tvalid && s_tready) begin
            in_reg <= s_tdata;
        end
        if (div_start) begin
            neg_reg <= num_reg[NUM_W-1] ^ area_reg[W_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_reg        <= S_AREA_P;
            acc_step_reg    <= S_AREA_P;
            acc_en_reg      <= 1'b0;
            last_reg        <= 1'b0;
            best_height_reg <= '0;
            any_hit_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_tuser_reg     <= 1'b0;
            m_tdata_reg     <= '0;
        end else begin
            acc_en_reg   <= (state_reg == ST_CALC) && (step_reg != S_DRAIN);
            acc_step_reg <= step_reg;
            // a result loaded in the finish step replaces the one leaving
            if (m_tvalid_reg && m_tready && !(state_reg == ST_FINISH && last_reg)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        last_reg  <= s_tlast;
                        step_reg  <= S_AREA_P;
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == S_DRAIN) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    state_reg <= hit ? ST_DIV : ST_FINISH;
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        if (!any_hit_reg || h_val > best_height_reg) begin
                            best_height_reg <= h_val;
                        end
                        any_hit_reg <= 1'b1;
                        state_reg   <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!last_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg    <= 1'b1;
                        m_tuser_reg     <= any_hit_reg;
                        m_tdata_reg     <= any_hit_reg ? HEIGHT_W'(best_height_reg) : '0;
                        best_height_reg <= '0;
                        any_hit_reg     <= 1'b0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a second triangle while busy");
    a_result_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(last_reg))
        else $error("result emitted for a non-final triangle");
    a_clear_best: assert property (@(posedge aclk) disable iff (!aresetn)
        !any_hit_reg |-> best_height_reg == '0)
        else $error("running maximum set without a hit");
    a_zero_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg) |-> m_tdata_reg == '0)
        else $error("nonzero height on a miss");

endmodule
